// File: src/scfc_pkg.sv
package scfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int SCALED_W = 15;
    localparam int POS_W    = 3;
    localparam int COEF_W   = 15;
    localparam int PROD_W   = COEF_W + WORD_W + 1;
    localparam int OUT_W    = WORD_W + 1 + SCALED_W;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Frame layout: two words of two bytes, each followed by its CRC byte
    localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
    localparam logic [POS_W-1:0] POS_LAST   = 3'd5;
    localparam logic [POS_W-1:0] CHAN_SPLIT = 3'd3;

    localparam logic CHAN_TEMP  = 1'b0;
    localparam logic CHAN_HUMID = 1'b1;

    // Fixed-point scaling: value = (coef * raw >> 16) - offset
    localparam logic [COEF_W-1:0]   TEMP_COEF    = 15'd17500;
    localparam logic [COEF_W-1:0]   HUMID_COEF   = 15'd10000;
    localparam logic [SCALED_W-1:0] TEMP_OFFSET  = 15'd4500;
    localparam logic [SCALED_W-1:0] HUMID_OFFSET = 15'd0;

    typedef enum logic [1:0] {
        SLOT_HIGH,
        SLOT_LOW,
        SLOT_CRC
    } word_slot_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              frame_start;
    } byte_req_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: src/scfc_in_stage.sv
module scfc_in_stage
    import scfc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  byte_req_t s_req,
    output logic      req_valid,
    output byte_req_t req,
    input  logic      req_take
);

    logic      in_valid_reg;
    logic      in_valid_next;
    byte_req_t in_req_reg;

    // Accept a new request when the slot is empty or drains this cycle
    assign s_tready = !in_valid_reg || req_take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg <= s_req;
        end
    end

    assign req_valid = in_valid_reg;
    assign req       = in_req_reg;

endmodule

// File: src/scfc_scale.sv
module scfc_scale
    import scfc_pkg::*;
(
    input  logic                       chan,
    input  logic [WORD_W-1:0]          raw,
    output logic signed [SCALED_W-1:0] scaled
);

    logic [COEF_W-1:0]   coef;
    logic [SCALED_W-1:0] offset;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] quot;

    assign coef   = (chan == CHAN_HUMID) ? HUMID_COEF : TEMP_COEF;
    assign offset = (chan == CHAN_HUMID) ? HUMID_OFFSET : TEMP_OFFSET;
    assign prod   = PROD_W'(coef) * PROD_W'(raw);
    // Floor of the product over 2^16
    assign quot   = prod[WORD_W +: SCALED_W];
    assign scaled = signed'(quot - offset);

endmodule

// File: src/scfc_frame_core.sv
module scfc_frame_core
    import scfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    input  byte_req_t        req,
    output logic             req_take,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [BYTE_W-1:0]          crc_reg, crc_next;
    logic [BYTE_W-1:0]          high_reg, high_next;
    logic [WORD_W-1:0]          word_reg, word_next;
    logic signed [SCALED_W-1:0] scaled_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_chan_reg;
    logic [WORD_W-1:0]          out_raw_reg;
    logic                       out_good_reg;
    logic signed [SCALED_W-1:0] out_scaled_reg;

    logic [POS_W-1:0]           pos;
    logic [POS_W-1:0]           sub_pos;
    logic                       chan;
    word_slot_t                 slot;
    logic [WORD_W-1:0]          new_word;
    logic signed [SCALED_W-1:0] new_scaled;
    logic                       emits;

    always_comb begin
        pos = req.frame_start ? POS_FIRST : pos_reg;
        if (pos > POS_LAST) begin
            pos = POS_FIRST;
        end
        chan    = (pos >= CHAN_SPLIT) ? CHAN_HUMID : CHAN_TEMP;
        sub_pos = (chan == CHAN_HUMID) ? (pos - CHAN_SPLIT) : pos;
        case (sub_pos)
            3'd0: slot = SLOT_HIGH;
            3'd1: slot = SLOT_LOW;
            default: slot = SLOT_CRC;
        endcase
    end

    assign new_word = {high_reg, req.byte_value};

    // Scale as soon as the word is complete; emit it with the CRC byte
    scfc_scale u_scale (
        .chan   (chan),
        .raw    (new_word),
        .scaled (new_scaled)
    );

    assign emits    = (slot == SLOT_CRC);
    assign req_take = req_valid && (!emits || !out_valid_reg || m_tready);

    always_comb begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        high_next = high_reg;
        word_next = word_reg;
        if (req_take) begin
            pos_next = (pos == POS_LAST) ? POS_FIRST : pos + 3'd1;
            case (slot)
                SLOT_HIGH: begin
                    crc_next  = crc8_byte(CRC_INIT, req.byte_value);
                    high_next = req.byte_value;
                end
                SLOT_LOW: begin
                    crc_next  = crc8_byte(crc_reg, req.byte_value);
                    word_next = new_word;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (req_take && emits) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FIRST;
            crc_reg       <= CRC_INIT;
            high_reg      <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take && slot == SLOT_LOW) begin
            scaled_reg <= new_scaled;
        end
        if (req_take && emits) begin
            out_chan_reg   <= chan;
            out_raw_reg    <= word_reg;
            out_good_reg   <= (crc_reg == req.byte_value);
            out_scaled_reg <= scaled_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_chan_reg;
    assign m_tdata  = {out_scaled_reg, out_good_reg, out_raw_reg};

endmodule

// File: src/sensor_frame_crc_checker.sv
// Channel   Dir  Handshake          tdata                                  tuser
// s_        in   s_tvalid/s_tready  [7:0] byte_value                       frame_start
// m_        out  m_tvalid/m_tready  [15:0] raw_word, [16] crc_good,        channel
//                                   [31:17] scaled_value (signed)
//
// One byte accepted per cycle while no stalled result holds the core; a result
// reaches the output through the input register and then the output register.
// The scaling multiply runs when the low word byte passes the core, so the CRC
// byte only compares and loads the output register.
// aresetn (synchronous) empties both registers and restarts the frame at byte 0.
// A stalled result holds the core only when the next byte is also a CRC byte.
module sensor_frame_crc_checker
    import scfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] byte_value
    input  logic             s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // [15:0] raw_word, [16] crc_good, [31:17] scaled_value
    output logic             m_tuser    // [0] channel
);

    byte_req_t s_req;
    byte_req_t req;
    logic      req_valid;
    logic      req_take;

    assign s_req.byte_value  = s_tdata;
    assign s_req.frame_start = s_tuser;

    scfc_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_req     (s_req),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    scfc_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// File: src/scfc_checker.sv
module scfc_checker
    import scfc_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [7:0]       s_tdata,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tuser
);

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties both stages
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("pipeline not empty after reset");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == CHAN_TEMP |->
            $signed(m_tdata[31:17]) >= -15'sd4500 && $signed(m_tdata[31:17]) <= 15'sd12999)
        else $error("temperature out of range");

    a_humid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == CHAN_HUMID |->
            $signed(m_tdata[31:17]) >= 15'sd0 && $signed(m_tdata[31:17]) <= 15'sd9999)
        else $error("humidity out of range");

endmodule

bind sensor_frame_crc_checker scfc_checker u_scfc_checker (.*);

// File: verif/tb_sensor_frame_crc_checker.sv
`timescale 1ns / 1ps

module tb_sensor_frame_crc_checker;
    import scfc_pkg::*;

    localparam int          TOTAL_REQUESTS = 1400;
    localparam int          IDLE_LIMIT     = 1000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          TEMP_GAIN      = 17500;
    localparam int          HUMID_GAIN     = 10000;
    localparam int          TEMP_BIAS      = 4500;
    localparam logic [7:0]  CRC_SEED       = 8'hFF;
    localparam logic [7:0]  CRC_GEN        = 8'h31;

    typedef struct {
        logic [7:0] byte_value;
        logic       frame_start;
    } byte_request_t;

    typedef struct {
        logic        channel;
        logic [15:0] raw_word;
        logic        crc_good;
        logic [14:0] scaled_value;
    } sensor_reading_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata  = '0;
    logic             s_tuser  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tuser;

    byte_request_t   pending_requests[$];
    sensor_reading_t expected_readings[$];

    // predictor state
    logic [2:0]  frame_pos  = POS_FIRST;
    logic [7:0]  word_crc   = CRC_SEED;
    logic [7:0]  word_high  = '0;
    logic [15:0] word_last  = '0;

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   s_delay  = 0;
    int   s_phase  = 0;
    bit   s_calm   = 1'b0;
    int   m_delay  = 0;
    int   m_phase  = 0;
    bit   m_calm   = 1'b0;
    int   idle_cycles = 0;

    int n_queued     = 0;
    int n_accepted   = 0;
    int n_temp       = 0;
    int n_humid      = 0;
    int n_bad_crc    = 0;
    int n_starts     = 0;
    int mismatches   = 0;

    sensor_frame_crc_checker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // MSB-first shift register form of the CRC-8
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_GEN : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc_of(input logic [15:0] w);
        return crc_step(crc_step(CRC_SEED, w[15:8]), w[7:0]);
    endfunction

    function automatic logic [14:0] scale_reading(input logic chan, input logic [15:0] raw);
        logic [31:0] prod;
        int          v;
        prod = (chan == CHAN_HUMID) ? HUMID_GAIN * raw : TEMP_GAIN * raw;
        v    = int'(prod >> 16) - ((chan == CHAN_HUMID) ? 0 : TEMP_BIAS);
        return v[14:0];
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Long runs of zero delay and runs of random delays follow in random order
    task automatic next_delay(inout int phase_left, inout bit calm, output int cycles);
        if (phase_left == 0) begin
            calm       = ($urandom_range(0, 2) == 0);
            phase_left = $urandom_range(10, 60);
        end else begin
            phase_left--;
        end
        cycles = calm ? 0 : $urandom_range(0, 16);
    endtask

    task automatic push_request(input logic [7:0] b, input logic fs);
        byte_request_t r;
        r.byte_value  = b;
        r.frame_start = fs;
        pending_requests.push_back(r);
        n_queued++;
    endtask

    task automatic push_word(input logic [15:0] w, input logic fs, input logic [7:0] crc_flip);
        push_request(w[15:8], fs);
        push_request(w[7:0], 1'b0);
        push_request(word_crc_of(w) ^ crc_flip, 1'b0);
    endtask

    task automatic predict_reading(input logic [7:0] b, input logic fs);
        logic [2:0]      pos;
        logic [2:0]      offs;
        logic            chan;
        word_slot_t      slot;
        sensor_reading_t r;
        pos  = fs ? POS_FIRST : frame_pos;
        if (pos > POS_LAST)
            pos = POS_FIRST;
        chan = (pos >= CHAN_SPLIT) ? CHAN_HUMID : CHAN_TEMP;
        offs = (chan == CHAN_HUMID) ? pos - CHAN_SPLIT : pos;
        slot = word_slot_t'(offs[1:0]);
        case (slot)
            SLOT_HIGH: begin
                word_crc  = crc_step(CRC_SEED, b);
                word_high = b;
            end
            SLOT_LOW: begin
                word_crc  = crc_step(word_crc, b);
                word_last = {word_high, b};
            end
            default: begin
                r.channel      = chan;
                r.raw_word     = word_last;
                r.crc_good     = (word_crc == b);
                r.scaled_value = scale_reading(chan, word_last);
                expected_readings.push_back(r);
            end
        endcase
        frame_pos = (pos == POS_LAST) ? POS_FIRST : pos + 3'd1;
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_reading();
        sensor_reading_t e;
        if (expected_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected result, tdata %h tuser %b", m_tdata, m_tuser));
        end else begin
            e = expected_readings.pop_front();
            if (m_tuser !== e.channel)
                report_mismatch($sformatf("channel %b, want %b", m_tuser, e.channel));
            if (m_tdata[WORD_W-1:0] !== e.raw_word)
                report_mismatch($sformatf("raw_word %h, want %h",
                                          m_tdata[WORD_W-1:0], e.raw_word));
            if (m_tdata[WORD_W] !== e.crc_good)
                report_mismatch($sformatf("crc_good %b, want %b (word %h)",
                                          m_tdata[WORD_W], e.crc_good, e.raw_word));
            if (m_tdata[OUT_W-1:WORD_W+1] !== e.scaled_value)
                report_mismatch($sformatf("scaled_value %0d, want %0d (word %h)",
                                          $signed(m_tdata[OUT_W-1:WORD_W+1]),
                                          $signed(e.scaled_value), e.raw_word));
            if (e.channel == CHAN_HUMID)
                n_humid++;
            else
                n_temp++;
            if (!e.crc_good)
                n_bad_crc++;
        end
    endtask

    // Driver: advance to the next request once the current one is taken
    always @(negedge aclk) begin
        byte_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (s_delay > 0) begin
                s_delay--;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                s_tdata  <= req.byte_value;
                s_tuser  <= req.frame_start;
                s_tvalid <= 1'b1;
                next_delay(s_phase, s_calm, s_delay);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: hold tready low for a drawn number of cycles after each result
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (out_fire)
                next_delay(m_phase, m_calm, m_delay);
            else if (!m_tready && m_delay > 0)
                m_delay--;
            m_tready <= (m_delay == 0);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end else begin
            in_fire  <= s_tvalid && s_tready;
            out_fire <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                predict_reading(s_tdata, s_tuser);
                n_accepted++;
                if (s_tuser)
                    n_starts++;
            end
            if (m_tvalid && m_tready)
                check_reading();
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0]  frame_bytes [6];
        logic [15:0] w;
        logic [7:0]  flip;
        logic        fs;
        int          kind;
        int          cut;

        // extremes with good CRCs, then a frame with no start mark and bad CRCs
        push_word(16'h0000, 1'b1, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'h00);
        push_word(16'hFFFF, 1'b0, 8'hFF);
        push_word(16'h0000, 1'b0, 8'h01);
        // published check value of this CRC
        push_request(8'hBE, 1'b1);
        push_request(8'hEF, 1'b0);
        push_request(8'h92, 1'b0);
        // restart in mid-frame where the humidity word would begin
        push_word(16'h8000, 1'b1, 8'h00);
        push_request(8'h7F, 1'b0);
        push_request(8'hFF, 1'b0);
        // restart on what would be a CRC byte
        push_word(16'h7FFF, 1'b1, 8'h00);
        push_word(16'h0001, 1'b0, 8'h00);

        while (n_queued < TOTAL_REQUESTS) begin
            kind = $urandom_range(0, 9);
            if (kind == 9) begin
                repeat ($urandom_range(1, 8))
                    push_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                fs = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < 2; k++) begin
                    w    = pick_word();
                    flip = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                    frame_bytes[3*k]   = w[15:8];
                    frame_bytes[3*k+1] = w[7:0];
                    frame_bytes[3*k+2] = word_crc_of(w) ^ flip;
                end
                // drop the tail of some frames
                cut = (kind == 8) ? $urandom_range(1, 5) : 6;
                for (int k = 0; k < cut; k++)
                    push_request(frame_bytes[k], fs && (k == 0));
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes (%0d with a frame mark); checked %0d temperature and %0d humidity",
                 n_accepted, n_starts, n_temp, n_humid);
        $display("results, %0d of them carrying a failed CRC", n_bad_crc);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
